[rtl/svsg_pkg.sv]
// Package: shared types and constants for the six-voice sound generator.
`timescale 1ns / 1ps
`default_nettype none
package svsg_pkg;
    localparam int NumChannels = 6;
    localparam int NumUnits = 2;

    typedef enum logic [1:0] {
        OP_ADDR = 2'd0,
        OP_DATA = 2'd1,
        OP_TICK = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    localparam logic [7:0] PtrLimit = 8'h20;
    localparam logic [9:0] NoiseDivReset = 10'h080;
    localparam logic [9:0] NoiseCntMax = 10'd1023;
    localparam logic [8:0] FreqBase = 9'd511;

    localparam logic [4:0] RegAmpLast = 5'h05;
    localparam logic [4:0] RegFreqFirst = 5'h08;
    localparam logic [4:0] RegFreqLast = 5'h0D;
    localparam logic [4:0] RegOctFirst = 5'h10;
    localparam logic [4:0] RegOctLast = 5'h12;
    localparam logic [4:0] RegToneEn = 5'h14;
    localparam logic [4:0] RegNoiseEn = 5'h15;
    localparam logic [4:0] RegNoiseMode = 5'h16;
    localparam logic [4:0] RegEnv0 = 5'h18;
    localparam logic [4:0] RegEnv1 = 5'h19;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] data_byte;
    } in_word_t;

    typedef struct packed {
        logic [6:0] left_level;
        logic [6:0] right_level;
    } out_word_t;
endpackage
`default_nettype wire

[rtl/svsg_if.sv]
// Interfaces: valid/ready channels for input and result words.
`timescale 1ns / 1ps
`default_nettype none
interface svsg_in_if;
    import svsg_pkg::*;
    logic     valid;
    logic     ready;
    in_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface svsg_out_if;
    import svsg_pkg::*;
    logic      valid;
    logic      ready;
    out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/six_voice_sound_generator.sv]
// Top level: six-voice tone/noise/envelope sound generator.
`timescale 1ns / 1ps
`default_nettype none
// Address and data writes give no word. A tick walks the six tone channels
// through one shared compare/counter unit, one channel per cycle (the
// envelope of a channel pair steps in the same cycle), then steps through the
// noise units, one per cycle, and through the channels on the mix sums, one
// per cycle, with a shared scale multiplier. The result word is registered
// as the block returns to idle, and the input is ready again from then on. A
// tick holds at its last mix step while the previous result still waits in the
// output register.
module six_voice_sound_generator
    import svsg_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    svsg_in_if.sink   in_ch,
    svsg_out_if.source out_ch
);
    typedef enum logic [1:0] {ST_IDLE, ST_TONE, ST_NOISE, ST_MIX} state_t;

    state_t      state_reg;
    logic [2:0]  idx_reg;
    logic [4:0]  ptr_reg;
    logic [7:0]  amp_reg [NumChannels];
    logic [7:0]  freq_reg [NumChannels];
    logic [2:0]  oct_reg [NumChannels];
    logic [5:0]  tone_en_reg, noise_en_reg;
    logic [1:0]  nmode_reg [NumUnits];
    logic [9:0]  ndiv_reg [NumUnits];
    logic [7:0]  ectl_reg [NumUnits];
    logic [4:0]  estep_reg [NumUnits];
    logic [3:0]  elvl_reg [NumUnits];
    logic [15:0] tcnt_reg [NumChannels];
    logic [9:0]  ncnt_reg [NumUnits];
    logic [15:0] nsh_reg [NumUnits];
    logic [1:0]  nbit_reg;
    logic [5:0]  tbit_reg;
    logic [5:0]  fire_reg;
    logic [6:0]  sum_l_reg, sum_r_reg;
    logic [6:0]  left_reg, right_reg;
    logic        out_valid_reg;
    logic        out_load;

    // Shared tone unit: period of the channel under idx_reg.
    logic [2:0]  ch;
    logic [15:0] period;
    logic        tfire;
    assign ch = (idx_reg < 3'd6) ? idx_reg : 3'd0;
    assign period = {7'd0, FreqBase - {1'b0, freq_reg[ch]}} << (3'd7 - oct_reg[ch]);
    assign tfire = ({1'b0, tcnt_reg[ch]} + 17'd1) >= {1'b0, period};

    // Envelope step for the unit clocked by this channel.
    logic       u;
    logic [7:0] ctl;
    logic [4:0] r, r_n, mx, top;
    logic [4:0] lvl;
    assign u = (ch >= 3'd3);
    always_comb
    begin
        ctl = ectl_reg[u];
        r = estep_reg[u];
        lvl = {1'b0, elvl_reg[u]};
        r_n = r;
        mx = ctl[4] ? 5'd7 : 5'd15;
        top = ctl[4] ? 5'd16 : 5'd0; // 32 wraps to 0 in 5 bits; used mod 32
        case (ctl[3:1])
            3'd0: lvl = 5'd0;
            3'd1: lvl = mx;
            3'd2:
            begin
                lvl = mx - r;
                if (r < mx) r_n = r + 5'd1;
            end
            3'd3:
            begin
                lvl = mx - r;
                r_n = (r < mx) ? r + 5'd1 : 5'd0;
            end
            3'd6:
            begin
                lvl = (r <= mx) ? r : 5'd0;
                if (r <= mx) r_n = r + 5'd1;
            end
            3'd7:
            begin
                lvl = r;
                r_n = (r < mx) ? r + 5'd1 : 5'd0;
            end
            3'd4:
            begin
                lvl = (r > mx) ? top - r - 5'd1 : r;
                if ({1'b0, r} < {ctl[4] ? 1'b0 : 1'b1, top} - 6'd1) r_n = r + 5'd1;
            end
            default:
            begin
                lvl = (r > mx) ? top - r - 5'd1 : r;
                r_n = r + 5'd1;
                if ({1'b0, r_n} >= {ctl[4] ? 1'b0 : 1'b1, top}) r_n = 5'd0;
            end
        endcase
    end

    // Noise unit and mix channel selection.
    logic        nu;
    logic        nfire;
    logic [15:0] nsh;
    assign nu = idx_reg[0];
    assign nsh = nsh_reg[nu];
    assign nfire = (nmode_reg[nu] == 2'd3) ? fire_reg[nu ? 3'd3 : 3'd0]
                 : ({1'b0, ncnt_reg[nu]} + 11'd1) >= {1'b0, ndiv_reg[nu]};

    logic       sig;
    logic [3:0] vl, vr, e, er;
    logic [7:0] pl, pr;
    logic [6:0] addl, addr_v;
    logic [7:0] mctl;
    assign mctl = ectl_reg[u];
    always_comb
    begin
        sig = tone_en_reg[ch] ? tbit_reg[ch] : 1'b1;
        if (noise_en_reg[ch]) sig = sig & nbit_reg[u];
        vl = amp_reg[ch][3:0];
        vr = amp_reg[ch][7:4];
        e = mctl[4] ? {1'b0, elvl_reg[u][2:0]} : elvl_reg[u];
        er = mctl[0] ? ((mctl[4] ? 4'd7 : 4'd15) - e) : e;
        pl = vl * e;
        pr = vr * er;
        if (!sig)
        begin
            addl = 7'd0;
            addr_v = 7'd0;
        end
        else if ((ch == 3'd2 || ch == 3'd5) && mctl[7])
        begin
            addl = mctl[4] ? {2'd0, pl[7:3]} : {3'd0, pl[7:4]};
            addr_v = mctl[4] ? {2'd0, pr[7:3]} : {3'd0, pr[7:4]};
        end
        else
        begin
            addl = {3'd0, vl};
            addr_v = {3'd0, vr};
        end
    end

    in_word_t w;
    assign w = in_ch.data;
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data = '{left_level: left_reg, right_level: right_reg};
    // last mix step may load the output once the previous word is gone
    assign out_load = (state_reg == ST_MIX) && (idx_reg == 3'd5)
                    && (!out_valid_reg || out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg <= '0;
            ptr_reg <= '0;
            out_valid_reg <= 1'b0;
            tone_en_reg <= '0;
            noise_en_reg <= '0;
            nbit_reg <= '0;
            tbit_reg <= '0;
            fire_reg <= '0;
            sum_l_reg <= '0;
            sum_r_reg <= '0;
            left_reg <= '0;
            right_reg <= '0;
            for (int i = 0; i < NumChannels; i++)
            begin
                amp_reg[i] <= '0;
                freq_reg[i] <= '0;
                oct_reg[i] <= '0;
                tcnt_reg[i] <= '0;
            end
            for (int i = 0; i < NumUnits; i++)
            begin
                nmode_reg[i] <= '0;
                ndiv_reg[i] <= NoiseDivReset;
                ectl_reg[i] <= '0;
                estep_reg[i] <= '0;
                elvl_reg[i] <= '0;
                ncnt_reg[i] <= '0;
                nsh_reg[i] <= '0;
            end
        end
        else
        begin
            if (out_load) out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ch.ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_ch.valid && in_ch.ready)
                    begin
                        case (w.operation)
                            OP_ADDR:
                                if (w.data_byte < PtrLimit) ptr_reg <= w.data_byte[4:0];
                            OP_DATA:
                            begin
                                if (ptr_reg <= RegAmpLast)
                                    amp_reg[ptr_reg[2:0]] <= w.data_byte;
                                else if (ptr_reg >= RegFreqFirst && ptr_reg <= RegFreqLast)
                                    freq_reg[ptr_reg[2:0]] <= w.data_byte;
                                else if (ptr_reg >= RegOctFirst && ptr_reg <= RegOctLast)
                                begin
                                    oct_reg[{ptr_reg[1:0], 1'b0}] <= w.data_byte[2:0];
                                    oct_reg[{ptr_reg[1:0], 1'b1}] <= w.data_byte[6:4];
                                end
                                else if (ptr_reg == RegToneEn)
                                    tone_en_reg <= w.data_byte[5:0];
                                else if (ptr_reg == RegNoiseEn)
                                    noise_en_reg <= w.data_byte[5:0];
                                else if (ptr_reg == RegNoiseMode)
                                begin
                                    nmode_reg[0] <= w.data_byte[1:0];
                                    nmode_reg[1] <= w.data_byte[5:4];
                                    if (w.data_byte[1:0] != 2'd3)
                                        ndiv_reg[0] <= NoiseDivReset << w.data_byte[1:0];
                                    if (w.data_byte[5:4] != 2'd3)
                                        ndiv_reg[1] <= NoiseDivReset << w.data_byte[5:4];
                                end
                                else if (ptr_reg == RegEnv0 || ptr_reg == RegEnv1)
                                    ectl_reg[ptr_reg[0]] <= w.data_byte;
                            end
                            OP_TICK:
                            begin
                                state_reg <= ST_TONE;
                                idx_reg <= '0;
                                sum_l_reg <= '0;
                                sum_r_reg <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_TONE:
                begin
                    fire_reg[ch] <= tfire;
                    if (tfire)
                    begin
                        tbit_reg[ch] <= ~tbit_reg[ch];
                        tcnt_reg[ch] <= '0;
                        if ((ch == 3'd1 || ch == 3'd4) && !ectl_reg[u][5])
                        begin
                            if (!ectl_reg[u][7])
                                estep_reg[u] <= '0;
                            else
                            begin
                                elvl_reg[u] <= lvl[3:0];
                                estep_reg[u] <= r_n;
                            end
                        end
                    end
                    else
                        tcnt_reg[ch] <= tcnt_reg[ch] + 16'd1;
                    if (idx_reg == 3'd5)
                    begin
                        idx_reg <= '0;
                        state_reg <= ST_NOISE;
                    end
                    else
                        idx_reg <= idx_reg + 3'd1;
                end
                ST_NOISE:
                begin
                    if (nfire)
                    begin
                        nsh_reg[nu] <= {nsh[14:0], ~(nbit_reg[nu] ^ nsh[13])};
                        nbit_reg[nu] <= nsh[15];
                        ncnt_reg[nu] <= '0;
                    end
                    else if (ncnt_reg[nu] < NoiseCntMax)
                        ncnt_reg[nu] <= ncnt_reg[nu] + 10'd1;
                    if (idx_reg == 3'd1)
                    begin
                        idx_reg <= '0;
                        state_reg <= ST_MIX;
                    end
                    else
                        idx_reg <= idx_reg + 3'd1;
                end
                ST_MIX:
                begin
                    if (idx_reg == 3'd5)
                    begin
                        if (out_load)
                        begin
                            left_reg <= sum_l_reg + addl;
                            right_reg <= sum_r_reg + addr_v;
                            idx_reg <= '0;
                            state_reg <= ST_IDLE;
                        end
                    end
                    else
                    begin
                        sum_l_reg <= sum_l_reg + addl;
                        sum_r_reg <= sum_r_reg + addr_v;
                        idx_reg <= idx_reg + 3'd1;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
